// File: rtl/pidaw_pkg.sv
package pidaw_pkg;

  // Field and state widths
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int DT_BITS   = 16;
  localparam int INTEG_W   = DATA_W + 16;
  localparam int DELTA_W   = DATA_W + 1;
  localparam int WIDE_W    = 60;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;

  // Signed working width for sums before saturation
  localparam int SUM_W   = WIDE_W + 2;
  localparam int ERR_X_W = DATA_W + 2;

  // Serial multiplier: multiplicand, multiplier and product widths
  localparam int MUL_AW = WIDE_W;
  localparam int MUL_BW = DATA_W + 2;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int SAT_MW = MUL_PW + 1;

  // Serial divider: numerator magnitude, divisor magnitude, dividend widths
  localparam int DIV_NMW = DATA_W + 2;
  localparam int DIV_DMW = DATA_W + 1;
  localparam int DIV_SH  = (FRAC_BITS > DT_BITS) ? FRAC_BITS : DT_BITS;
  localparam int DIV_NW  = DIV_NMW + DIV_SH;

  // Limiting modes
  localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLIP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACKCALC = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COND     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FILTER   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_AW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MODE = 3'd6;

  // Arithmetic steps of one sample
  typedef enum logic [2:0] {
    OP_AW, OP_INC, OP_DER, OP_P, OP_DT, OP_IT, OP_BC
  } op_t;

  // Saturation target of a unit result
  typedef enum logic [1:0] {
    SW_DELTA, SW_INTEG, SW_WIDE
  } sat_w_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic div_start;
    op_t  op;
    logic comb;
    logic commit;
    logic hold;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic filter;
    logic backcalc;
    logic mul_done;
    logic div_done;
  } stat_t;

  // Sign and magnitude to a saturated signed value
  function automatic logic signed [WIDE_W-1:0] sat_mag(input logic [SAT_MW-1:0] m,
                                                       input logic neg,
                                                       input sat_w_t sw);
    logic [SAT_MW-1:0] lim;
    logic [WIDE_W-1:0] v;
    case (sw)
      SW_DELTA: lim = SAT_MW'(1) << (DELTA_W - 1);
      SW_INTEG: lim = SAT_MW'(1) << (INTEG_W - 1);
      default:  lim = SAT_MW'(1) << (WIDE_W - 1);
    endcase
    if (neg) begin
      v = (m >= lim) ? WIDE_W'(SAT_MW'(0) - lim) : WIDE_W'(SAT_MW'(0) - m);
    end else begin
      v = (m >= lim) ? WIDE_W'(lim - SAT_MW'(1)) : WIDE_W'(m);
    end
    return signed'(v);
  endfunction

  // Signed saturation to w bits
  function automatic logic signed [WIDE_W-1:0] sat_s(input logic signed [SUM_W-1:0] x,
                                                     input int unsigned w);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = signed'((SUM_W'(1) << (w - 1)) - SUM_W'(1));
    lo = ~hi;
    if (x > hi) return WIDE_W'(hi);
    else if (x < lo) return WIDE_W'(lo);
    else return WIDE_W'(x);
  endfunction

endpackage

// File: rtl/pidaw_mul.sv
module pidaw_mul
  import pidaw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  input  logic                     sh_dt,
  input  sat_w_t                   sat_w,
  output logic                     done,
  output logic signed [WIDE_W-1:0] res
);

  localparam int CNT_W = $clog2(MUL_BW + 1);
  localparam logic [SAT_MW-1:0] HALF_F = SAT_MW'(1) << (FRAC_BITS - 1);
  localparam logic [SAT_MW-1:0] HALF_T = SAT_MW'(1) << (DT_BITS - 1);

  logic              busy;
  logic              fin;
  logic [CNT_W-1:0]  cnt;
  logic [MUL_AW-1:0] amag;
  logic [MUL_PW-1:0] acc;
  logic              neg;
  sat_w_t            sw_r;
  logic              dt_r;
  logic [MUL_AW:0]   psum;
  logic [SAT_MW-1:0] rnd;

  // One multiplier bit a cycle, product shifts right through acc
  always_comb begin
    psum = {1'b0, acc[MUL_PW-1:MUL_BW]} + (acc[0] ? {1'b0, amag} : '0);
    if (dt_r) rnd = ({1'b0, acc} + HALF_T) >> DT_BITS;
    else      rnd = ({1'b0, acc} + HALF_F) >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        amag <= a[MUL_AW-1] ? unsigned'(-a) : unsigned'(a);
        acc  <= {{MUL_AW{1'b0}}, (b[MUL_BW-1] ? unsigned'(-b) : unsigned'(b))};
        neg  <= a[MUL_AW-1] ^ b[MUL_BW-1];
        sw_r <= sat_w;
        dt_r <= sh_dt;
      end else if (busy) begin
        acc <= {psum, acc[MUL_BW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_BW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        res  <= sat_mag(rnd, neg, sw_r);
      end
    end
  end

endmodule

// File: rtl/pidaw_div.sv
module pidaw_div
  import pidaw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [DIV_NMW-1:0] num,
  input  logic signed [DIV_DMW-1:0] den,
  input  logic                      sh_dt,
  input  sat_w_t                    sat_w,
  output logic                      done,
  output logic signed [WIDE_W-1:0]  res
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic               busy;
  logic               fin;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_NW-1:0]  quo;
  logic [DIV_DMW-1:0] rem;
  logic [DIV_DMW-1:0] dmag;
  logic               neg;
  sat_w_t             sw_r;
  logic [DIV_NMW-1:0] nmag;
  logic [DIV_NW-1:0]  dividend;
  logic [DIV_DMW:0]   shifted;
  logic [DIV_DMW:0]   diff;
  logic               ge;

  // Restoring division, one quotient bit a cycle
  always_comb begin
    nmag = num[DIV_NMW-1] ? unsigned'(-num) : unsigned'(num);
    if (sh_dt) dividend = DIV_NW'(nmag) << DT_BITS;
    else       dividend = DIV_NW'(nmag) << FRAC_BITS;
    shifted = {rem, quo[DIV_NW-1]};
    diff    = shifted - {1'b0, dmag};
    ge      = shifted >= {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dmag <= den[DIV_DMW-1] ? unsigned'(-den) : unsigned'(den);
        neg  <= num[DIV_NMW-1] ^ den[DIV_DMW-1];
        sw_r <= sat_w;
      end else if (busy) begin
        rem <= ge ? diff[DIV_DMW-1:0] : shifted[DIV_DMW-1:0];
        quo <= {quo[DIV_NW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        res  <= sat_mag(SAT_MW'(quo), neg, sw_r);
      end
    end
  end

endmodule

// File: rtl/pidaw_dp.sv
module pidaw_dp
  import pidaw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    st,
  input  logic signed [DATA_W-1:0] error_in,
  input  logic [DT_BITS-1:0]       time_step,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_idx,
  input  logic [DATA_W-1:0]        cfg_data,
  output logic signed [DATA_W-1:0] control_out,
  output logic                     was_clipped,
  output logic                     held
);

  // Configuration
  logic signed [DATA_W-1:0]  gain_p, gain_i, gain_d, gain_aw, out_low, out_high;
  logic [MODE_W-1:0]         limit_mode;
  // Controller state
  logic signed [DATA_W-1:0]  last_error, last_output;
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [DELTA_W-1:0] windup_delta;
  // Working registers of the current sample
  logic signed [DATA_W-1:0]  err_r;
  logic [DT_BITS-1:0]        dt_r;
  logic signed [DELTA_W-1:0] aw_r, val_r;
  logic signed [INTEG_W-1:0] i_new;
  logic signed [WIDE_W-1:0]  d_r, p_r, dterm_r, iterm_r;
  logic signed [DATA_W-1:0]  y_r, clip_pd_r;
  logic                      clipped_r;

  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [MUL_BW-1:0]  mul_b;
  logic                      mul_dt;
  sat_w_t                    mul_sw;
  logic                      mul_done;
  logic signed [WIDE_W-1:0]  mul_res;
  logic signed [DIV_NMW-1:0] div_num;
  logic signed [DIV_DMW-1:0] div_den;
  logic                      div_dt;
  sat_w_t                    div_sw;
  logic                      div_done;
  logic signed [WIDE_W-1:0]  div_res;

  logic signed [ERR_X_W-1:0] e_aw;
  logic signed [SUM_W-1:0]   pd, vsum;
  logic signed [DELTA_W-1:0] val;
  logic signed [DATA_W-1:0]  y, clip_pd;
  logic                      clipped;

  function automatic logic signed [DATA_W-1:0] clip_f(input logic signed [SUM_W-1:0] x,
                                                      input logic signed [DATA_W-1:0] lo,
                                                      input logic signed [DATA_W-1:0] hi);
    if (x < SUM_W'(lo)) return lo;
    else if (x > SUM_W'(hi)) return hi;
    else return DATA_W'(x);
  endfunction

  // Operand selection for the shared units
  always_comb begin
    e_aw   = ERR_X_W'(err_r) - ERR_X_W'(aw_r);
    mul_a  = MUL_AW'(err_r);
    mul_b  = MUL_BW'(gain_p);
    mul_dt = 1'b0;
    mul_sw = SW_WIDE;
    case (cmd.op)
      OP_AW: begin
        mul_a  = MUL_AW'(windup_delta);
        mul_b  = MUL_BW'(gain_aw);
        mul_sw = SW_DELTA;
      end
      OP_INC: begin
        mul_a  = MUL_AW'(e_aw);
        mul_b  = MUL_BW'(dt_r);
        mul_dt = 1'b1;
      end
      OP_DT: begin
        mul_a = d_r;
        mul_b = MUL_BW'(gain_d);
      end
      OP_IT: begin
        mul_a = MUL_AW'(i_new);
        mul_b = MUL_BW'(gain_i);
      end
      default: ;
    endcase
    if (cmd.op == OP_BC) begin
      div_num = DIV_NMW'(y_r) - DIV_NMW'(clip_pd_r);
      div_den = DIV_DMW'(gain_i);
      div_dt  = 1'b0;
      div_sw  = SW_INTEG;
    end else begin
      div_num = DIV_NMW'(err_r) - DIV_NMW'(last_error);
      div_den = DIV_DMW'(dt_r);
      div_dt  = 1'b1;
      div_sw  = SW_WIDE;
    end
  end

  pidaw_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh_dt (mul_dt),
    .sat_w (mul_sw),
    .done  (mul_done),
    .res   (mul_res)
  );

  pidaw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .sh_dt (div_dt),
    .sat_w (div_sw),
    .done  (div_done),
    .res   (div_res)
  );

  // Sum, saturation and limiting
  always_comb begin
    pd   = SUM_W'(p_r) + SUM_W'(dterm_r);
    vsum = pd + SUM_W'(iterm_r);
    val  = DELTA_W'(sat_s(vsum, DELTA_W));
    if (limit_mode == MODE_NONE) y = DATA_W'(sat_s(SUM_W'(val), DATA_W));
    else                         y = clip_f(SUM_W'(val), out_low, out_high);
    clipped = DELTA_W'(y) != val;
    clip_pd = clip_f(pd, out_low, out_high);
  end

  always_comb begin
    st.dt_zero  = dt_r == '0;
    st.filter   = limit_mode == MODE_FILTER;
    st.backcalc = (limit_mode == MODE_BACKCALC) && (gain_i != '0);
    st.mul_done = mul_done;
    st.div_done = div_done;
  end

  // Configuration and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= DATA_W'(1) << FRAC_BITS;
      gain_i       <= '0;
      gain_d       <= '0;
      gain_aw      <= '0;
      out_low      <= {1'b1, {(DATA_W-1){1'b0}}};
      out_high     <= {1'b0, {(DATA_W-1){1'b1}}};
      limit_mode   <= MODE_NONE;
      last_error   <= '0;
      integ_acc    <= '0;
      last_output  <= '0;
      windup_delta <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_GAIN_P:   gain_p   <= cfg_data;
          REG_GAIN_I:   gain_i   <= cfg_data;
          REG_GAIN_D:   gain_d   <= cfg_data;
          REG_GAIN_AW:  gain_aw  <= cfg_data;
          REG_OUT_LOW:  out_low  <= cfg_data;
          REG_OUT_HIGH: out_high <= cfg_data;
          REG_LIMIT_MODE: begin
            if (cfg_data[MODE_W-1:0] != limit_mode) begin
              limit_mode   <= cfg_data[MODE_W-1:0];
              windup_delta <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.commit && !cmd.hold) begin
        last_error  <= err_r;
        last_output <= y_r;
        if (!((limit_mode == MODE_COND) && clipped_r)) integ_acc <= i_new;
        if (limit_mode == MODE_FILTER) begin
          windup_delta <= DELTA_W'(sat_s(SUM_W'(val_r) - SUM_W'(y_r), DELTA_W));
        end
      end
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r <= error_in;
      dt_r  <= time_step;
      aw_r  <= '0;
    end
    if (mul_done) begin
      case (cmd.op)
        OP_AW:  aw_r    <= DELTA_W'(mul_res);
        OP_INC: i_new   <= INTEG_W'(sat_s(SUM_W'(integ_acc) + SUM_W'(mul_res), INTEG_W));
        OP_P:   p_r     <= mul_res;
        OP_DT:  dterm_r <= mul_res;
        OP_IT:  iterm_r <= mul_res;
        default: ;
      endcase
    end
    if (div_done) begin
      case (cmd.op)
        OP_DER:  d_r   <= div_res;
        OP_BC:   i_new <= INTEG_W'(div_res);
        default: ;
      endcase
    end
    if (cmd.comb) begin
      val_r     <= val;
      y_r       <= y;
      clipped_r <= clipped;
      clip_pd_r <= clip_pd;
    end
    if (cmd.commit) begin
      if (cmd.hold) begin
        control_out <= last_output;
        was_clipped <= 1'b0;
        held        <= 1'b1;
      end else begin
        control_out <= y_r;
        was_clipped <= clipped_r;
        held        <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/pidaw_ctrl.sv
module pidaw_ctrl
  import pidaw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ISSUE, S_WAIT, S_COMB, S_COMMIT
  } state_t;

  state_t state;
  op_t    op_r;
  logic   hold_r;
  logic   out_free;

  always_comb begin
    s_tready      = state == S_IDLE;
    out_free      = !m_tvalid || m_tready;
    cmd.load      = s_tvalid && s_tready;
    cmd.mul_start = (state == S_ISSUE) && (op_r != OP_DER) && (op_r != OP_BC);
    cmd.div_start = (state == S_ISSUE) && ((op_r == OP_DER) || (op_r == OP_BC));
    cmd.op        = op_r;
    cmd.comb      = state == S_COMB;
    cmd.commit    = (state == S_COMMIT) && out_free;
    cmd.hold      = hold_r;
  end

  // Step sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op_r     <= OP_INC;
      hold_r   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && !cmd.commit) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_START;
        end
        S_START: begin
          if (st.dt_zero) begin
            hold_r <= 1'b1;
            state  <= S_COMMIT;
          end else begin
            op_r  <= st.filter ? OP_AW : OP_INC;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (st.mul_done || st.div_done) begin
            state <= S_ISSUE;
            case (op_r)
              OP_AW:   op_r  <= OP_INC;
              OP_INC:  op_r  <= OP_DER;
              OP_DER:  op_r  <= OP_P;
              OP_P:    op_r  <= OP_DT;
              OP_DT:   op_r  <= OP_IT;
              OP_IT:   state <= S_COMB;
              OP_BC:   state <= S_COMMIT;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_COMB: begin
          if (st.backcalc) begin
            op_r  <= OP_BC;
            state <= S_ISSUE;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            hold_r   <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A unit only finishes while its step is awaited
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    (st.mul_done || st.div_done) |-> state == S_WAIT)
    else $error("unit finished outside a wait step");

  // A new result appears only out of the commit step
  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_COMMIT)
    else $error("output valid raised outside commit");

  // A wait ends only in a known successor
  a_wait_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |=> (state == S_WAIT || state == S_ISSUE ||
                         state == S_COMB || state == S_COMMIT))
    else $error("bad exit from wait step");

  // The hold flag never survives into a new sample
  a_hold_clear: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !hold_r)
    else $error("hold flag still set at accept");

endmodule

// File: rtl/pid_controller_antiwindup_core.sv
// Parallel-form PID controller with output limiting and anti-windup.
// Slave stream: one beat per sample, s_tdata = error_in (Q16.16) then
// time_step (Q0.16). Master stream: one beat per sample, m_tdata = the
// limited output, m_tuser = was_clipped, held.
// The user writes gains, limits and limit_mode on the cfg port while idle;
// the core does not check it. One sample at a time: a serial 60x34
// multiplier and a serial restoring divider are shared by all terms.
// Filtering mode adds a windup product step and back-calculation a
// further division step; a zero time step goes straight to the commit
// step. s_tready rises again in the same cycle that the result is
// registered.
// The result sits in an output register; a new sample is accepted while it
// waits, and the next result stalls in its commit step until m_tready
// frees the register.
// rst (synchronous) restores the default gains and limits, clears the
// integral, last error, last output and windup term, and empties the
// output register.
module pid_controller_antiwindup_core
  import pidaw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // error_in[31:0], time_step[47:32]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // control_out[31:0]
  output logic [1:0]           m_tuser,   // was_clipped[0], held[1]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_data
);

  cmd_t                     cmd;
  stat_t                    st;
  logic signed [DATA_W-1:0] control_out;
  logic                     was_clipped;
  logic                     held;

  pidaw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  pidaw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .error_in    (signed'(s_tdata[DATA_W-1:0])),
    .time_step   (s_tdata[DATA_W+DT_BITS-1:DATA_W]),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .control_out (control_out),
    .was_clipped (was_clipped),
    .held        (held)
  );

  assign m_tdata = control_out;
  assign m_tuser = {held, was_clipped};

endmodule

// File: dv/pid_output_checker.sv
`timescale 1ns / 100ps

// Watches the sample, result and register ports, predicts each result and
// compares it with what the core returns.
module pid_output_checker
  import pidaw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [47:0]          s_tdata,   // error_in[31:0], time_step[47:32]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [31:0]          m_tdata,   // control_out[31:0]
  input  logic [1:0]           m_tuser,   // was_clipped[0], held[1]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   n_results,
  output int                   n_clipped,
  output int                   n_held
);

  typedef struct {
    logic [31:0] ctrl;
    logic        clipped;
    logic        held;
  } pid_result_t;

  localparam logic [127:0] MAG_CAP = 128'd1 << 62;

  pid_result_t expected_q[$];

  // Predictor copy of the registers and loop state
  longint      kp, ki, kd, kaw, lim_lo, lim_hi;
  logic [2:0]  mode;
  longint      prev_err, integ, prev_out, wind_delta;

  initial begin
    errors = 0;
    pending = 0;
    n_results = 0;
    n_clipped = 0;
    n_held = 0;
  end

  function automatic longint sat_to(longint x, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return (x > hi) ? hi : ((x < lo) ? lo : x);
  endfunction

  function automatic longint from_mag(logic [127:0] m, bit neg, int w);
    longint v;
    if (m > MAG_CAP) m = MAG_CAP;
    v = longint'(m[63:0]);
    return sat_to(neg ? -v : v, w);
  endfunction

  // a*b / 2^sh, rounded half away from zero
  function automatic longint mul_round(longint a, longint b, int sh, int w);
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] pr;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    pr = ua * ub;
    if (sh > 0) pr = (pr + (128'd1 << (sh - 1))) >> sh;
    if (pr[127:64] != 0) pr = MAG_CAP;
    return from_mag(pr, neg, w);
  endfunction

  // num * 2^sh / den, truncated toward zero
  function automatic longint div_trunc(longint num, longint den, int sh, int w);
    logic [127:0] un;
    logic [127:0] ud;
    bit           neg;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? 128'(-num) : 128'(num);
    ud = (den < 0) ? 128'(-den) : 128'(den);
    return from_mag((un << sh) / ud, neg, w);
  endfunction

  function automatic longint clip_out(longint x);
    if (x < lim_lo) return lim_lo;
    if (x > lim_hi) return lim_hi;
    return x;
  endfunction

  function automatic pid_result_t predict_sample(logic [31:0] e_raw, logic [15:0] dt_raw);
    longint      e, dt, aw, inc, i_old, i_new, d, p, dterm, iterm, pd, value, y;
    pid_result_t r;
    e = longint'($signed(e_raw));
    dt = longint'(dt_raw);
    // zero step: repeat the last output, nothing moves
    if (dt == 0) begin
      r.ctrl = prev_out[31:0];
      r.clipped = 1'b0;
      r.held = 1'b1;
      return r;
    end
    aw = mul_round(kaw, wind_delta, FRAC_BITS, DELTA_W);
    inc = mul_round(e - aw, dt, DT_BITS, WIDE_W);
    i_old = integ;
    i_new = sat_to(i_old + inc, INTEG_W);
    d = div_trunc(e - prev_err, dt, DT_BITS, WIDE_W);
    p = mul_round(kp, e, FRAC_BITS, WIDE_W);
    dterm = mul_round(kd, d, FRAC_BITS, WIDE_W);
    iterm = mul_round(ki, i_new, FRAC_BITS, WIDE_W);
    pd = p + dterm;
    value = sat_to(pd + iterm, DELTA_W);
    y = (mode == MODE_NONE) ? sat_to(value, DATA_W) : clip_out(value);
    // anti-windup rules
    if (mode == MODE_BACKCALC) begin
      if (ki != 0) i_new = div_trunc(y - clip_out(pd), ki, FRAC_BITS, INTEG_W);
    end else if (mode == MODE_COND) begin
      if (y != value) i_new = i_old;
    end else if (mode == MODE_FILTER) begin
      wind_delta = sat_to(value - y, DELTA_W);
    end
    integ = i_new;
    prev_err = e;
    prev_out = y;
    r.ctrl = y[31:0];
    r.clipped = (y != value);
    r.held = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pid_result_t r;
    if (rst) begin
      kp = longint'(1) << FRAC_BITS;
      ki = 0;
      kd = 0;
      kaw = 0;
      lim_lo = sat_to(64'h8000_0000_0000_0000, DATA_W);
      lim_hi = sat_to(64'h7fff_ffff_ffff_ffff, DATA_W);
      mode = MODE_NONE;
      prev_err = 0;
      integ = 0;
      prev_out = 0;
      wind_delta = 0;
      expected_q.delete();
    end else begin
      // result beat
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat", m_tdata, 32'h0);
        end else begin
          r = expected_q.pop_front();
          n_results++;
          if (r.clipped) n_clipped++;
          if (r.held) n_held++;
          if (m_tdata !== r.ctrl) report_mismatch("control_out", m_tdata, r.ctrl);
          if (m_tuser[0] !== r.clipped)
            report_mismatch("was_clipped", 32'(m_tuser[0]), 32'(r.clipped));
          if (m_tuser[1] !== r.held)
            report_mismatch("held", 32'(m_tuser[1]), 32'(r.held));
        end
      end
      // register write
      if (cfg_we) begin
        case (cfg_idx)
          REG_GAIN_P:   kp = longint'($signed(cfg_data));
          REG_GAIN_I:   ki = longint'($signed(cfg_data));
          REG_GAIN_D:   kd = longint'($signed(cfg_data));
          REG_GAIN_AW:  kaw = longint'($signed(cfg_data));
          REG_OUT_LOW:  lim_lo = longint'($signed(cfg_data));
          REG_OUT_HIGH: lim_hi = longint'($signed(cfg_data));
          REG_LIMIT_MODE: begin
            // a change of mode drops the windup term
            if (cfg_data[2:0] != mode) begin
              mode = cfg_data[2:0];
              wind_delta = 0;
            end
          end
          default: ;
        endcase
      end
      // sample beat
      if (s_tvalid && s_tready) expected_q.push_back(predict_sample(s_tdata[31:0], s_tdata[47:32]));
    end
    pending = expected_q.size();
  end

endmodule

// File: dv/pid_controller_antiwindup_core_tb.sv
`timescale 1ns / 100ps

module pid_controller_antiwindup_core_tb;
  import pidaw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int N_PHASES  = 12;
  localparam int PHASE_LEN = 138;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  int errors, pending, n_results, n_clipped, n_held;
  int tx_idle_pct = 13;
  int rx_idle_pct = 55;
  int n_samples = 0;

  always #5 clk = ~clk;

  pid_controller_antiwindup_core u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tuser, .cfg_we, .cfg_idx, .cfg_data
  );

  pid_output_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tuser, .cfg_we, .cfg_idx, .cfg_data, .errors, .pending, .n_results,
    .n_clipped, .n_held
  );

  // result side back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

  // one sample beat, with an optional gap in front of it
  task automatic send_sample(logic [31:0] err, logic [15:0] dt);
    bit ready_seen;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {dt, err};
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
    n_samples++;
  endtask

  // drain every outstanding result, then let the core settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_all(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [31:0] aw,
                         logic [31:0] lo, logic [31:0] hi, logic [2:0] md);
    cfg_write(REG_GAIN_P, p);
    cfg_write(REG_GAIN_I, i);
    cfg_write(REG_GAIN_D, d);
    cfg_write(REG_GAIN_AW, aw);
    cfg_write(REG_OUT_LOW, lo);
    cfg_write(REG_OUT_HIGH, hi);
    cfg_write(REG_LIMIT_MODE, 32'(md));
  endtask

  function automatic logic [31:0] rand_err();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      4, 5, 6:    return $urandom();
      7:          return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 13))
      0:          return 16'h0;
      1:          return 16'hffff;
      2:          return 16'h1;
      3, 4, 5, 6: return 16'($urandom_range(1, 4096));
      default:    return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_gain(bit wild);
    if (wild) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        default: return $urandom();
      endcase
    end
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'h0001_0000;
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  initial begin
    logic [31:0] lo, hi, tmp;
    bit wild;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default settings, field extremes and the hold case
    send_sample(32'h7fff_ffff, 16'hffff);
    send_sample(32'h8000_0000, 16'h0001);
    send_sample(32'h0, 16'h0);
    send_sample(32'hffff_ffff, 16'h8000);
    send_sample(32'h0001_0000, 16'h0);
    drain();

    // filtering with tight limits so that the windup term builds up
    cfg_all(32'h0002_0000, 32'h0001_8000, 32'h0000_4000, 32'h0000_8000,
            32'hffff_0000, 32'h0001_0000, MODE_FILTER);
    send_sample(32'h0004_0000, 16'h1000);
    send_sample(32'h0004_0000, 16'h1000);
    send_sample(32'hfff8_0000, 16'h2000);
    send_sample(32'h0, 16'h0);
    drain();

    // back-calculation with a zero integral gain, then a nonzero one
    cfg_write(REG_GAIN_I, 32'h0);
    cfg_write(REG_LIMIT_MODE, 32'(MODE_BACKCALC));
    send_sample(32'h0008_0000, 16'h4000);
    send_sample(32'h0008_0000, 16'h4000);
    drain();
    cfg_write(REG_GAIN_I, 32'hfffe_0000);
    send_sample(32'h0008_0000, 16'h4000);
    send_sample(32'h8000_0000, 16'hffff);
    drain();

    // conditional integration, crossed limits, an unused mode, a stray index
    cfg_write(REG_LIMIT_MODE, 32'(MODE_COND));
    send_sample(32'h0010_0000, 16'h2000);
    send_sample(32'hffff_f000, 16'h2000);
    drain();
    cfg_write(REG_OUT_LOW, 32'h0002_0000);
    cfg_write(REG_OUT_HIGH, 32'hfffe_0000);
    cfg_write(REG_UNUSED, 32'h1234_5678);
    cfg_write(REG_LIMIT_MODE, 32'd7);
    send_sample(32'h0003_0000, 16'h1000);
    send_sample(32'hfffd_0000, 16'h1000);
    send_sample(32'h0, 16'h1000);
    drain();
    cfg_write(REG_LIMIT_MODE, 32'(MODE_CLIP));
    send_sample(32'h7fff_ffff, 16'hffff);
    send_sample(32'h8000_0000, 16'hffff);
    drain();

    // random phases, each with fresh settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 13;
        rx_idle_pct = 55;
      end else if (ph < 8) begin
        tx_idle_pct = 55;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wild = (ph % 4 == 1);
      case ($urandom_range(0, 5))
        0: begin
          lo = 32'h8000_0000;
          hi = 32'h7fff_ffff;
        end
        1: begin
          lo = $urandom();
          hi = $urandom();
        end
        default: begin
          lo = -32'($urandom_range(1, 32'h0040_0000));
          hi = 32'($urandom_range(0, 32'h0040_0000));
        end
      endcase
      if (ph == 6) begin
        tmp = lo;
        lo = hi + 32'h0001_0000;
        hi = tmp;
      end
      cfg_all(rand_gain(wild), rand_gain(wild), rand_gain(wild), rand_gain(wild), lo, hi,
              3'(ph % 8));
      for (int k = 0; k < PHASE_LEN; k++) send_sample(rand_err(), rand_dt());
      drain();
    end

    $display("covered %0d samples: %0d results, %0d clipped, %0d held",
             n_samples, n_results, n_clipped, n_held);
    $display("all limit modes, crossed limits and both idling patterns exercised");
    if (errors == 0) begin
      $display("pid_controller_antiwindup_core_tb: done, clean");
    end else begin
      $display("pid_controller_antiwindup_core_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(40_000_000);
    $display("timeout with %0d results outstanding", pending);
    $display("pid_controller_antiwindup_core_tb: done, errors");
    $finish;
  end

endmodule
